// ===== rtl/levenshtein_edit_distance_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the edit distance block
// Concurrent checks on clk with rst masking; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef LEVENSHTEIN_EDIT_DISTANCE_MACROS_SVH
`define LEVENSHTEIN_EDIT_DISTANCE_MACROS_SVH

`ifndef SYNTHESIS

`define LED_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define LED_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define LED_ASSERT_IMP(label, ante, cons)

`define LED_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== rtl/led_pkg.sv =====
// ----------------------------------------------------------------------------
// Edit distance package
// Sizes, op codes, the word that travels down the cell row, helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package led_pkg;

  localparam int MAX_QUERY_CHARS = 32;
  localparam int CHAR_W          = 32;
  localparam int DIST_W          = 7;
  localparam int OP_W            = 2;
  localparam int IDX_W           = $clog2(MAX_QUERY_CHARS + 1);

  localparam logic [DIST_W-1:0] SAT_MAX = 7'd127;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_CHAR   = 2'd2;
  localparam logic [OP_W-1:0] OP_END    = 2'd3;

  typedef struct packed {
    logic              valid;
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] char_code;
    logic [DIST_W-1:0] left;
    logic [DIST_W-1:0] diag;
    logic [DIST_W-1:0] result;
    logic              placed;
  } tok_t;

  function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] v);
    return (v == SAT_MAX) ? SAT_MAX : v + 7'd1;
  endfunction

  function automatic logic [DIST_W-1:0] reload_val(input logic [IDX_W-1:0] idx);
    logic [IDX_W+DIST_W-1:0] wide;
    wide = (IDX_W + DIST_W)'(idx);
    return (wide > (IDX_W + DIST_W)'(SAT_MAX)) ? SAT_MAX : wide[DIST_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/led_cell.sv =====
// ----------------------------------------------------------------------------
// Edit distance cell
// Holds one query character and one row entry; updates on the passing word.
// ----------------------------------------------------------------------------
`default_nettype none

module led_cell (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic [led_pkg::IDX_W-1:0]  idx,
  input  wire led_pkg::tok_t              tin,
  output led_pkg::tok_t                   tout
);

  logic [led_pkg::CHAR_W-1:0] qchar;
  logic                       qvalid;
  logic [led_pkg::DIST_W-1:0] val;
  logic [led_pkg::DIST_W-1:0] val_next;
  logic [led_pkg::DIST_W-1:0] m;
  logic [led_pkg::DIST_W-1:0] cand;
  logic                       qvalid_next;
  logic                       store;
  led_pkg::tok_t              tout_next;

  always_comb begin
    m = (tin.left < val) ? tin.left : val;
    if (tin.diag < m) begin
      m = tin.diag;
    end
    cand = (qchar == tin.char_code) ? tin.diag : led_pkg::sat_inc(m);
  end

  always_comb begin
    tout_next   = tin;
    val_next    = val;
    qvalid_next = qvalid;
    store       = 1'b0;
    case (tin.op)
      led_pkg::OP_CLEAR: begin
        qvalid_next = 1'b0;
        val_next    = led_pkg::reload_val(idx);
      end
      led_pkg::OP_APPEND: begin
        if (!qvalid && !tin.placed) begin
          store            = 1'b1;
          qvalid_next      = 1'b1;
          tout_next.placed = 1'b1;
        end
        val_next = led_pkg::reload_val(idx);
      end
      led_pkg::OP_CHAR: begin
        if (qvalid) begin
          val_next       = cand;
          tout_next.left = cand;
          tout_next.diag = val;
        end
      end
      led_pkg::OP_END: begin
        if (qvalid) begin
          tout_next.result = val;
        end
        val_next = led_pkg::reload_val(idx);
      end
      default: begin
        val_next = val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qvalid     <= 1'b0;
      val        <= led_pkg::reload_val(idx);
      tout.valid <= 1'b0;
    end else if (en) begin
      tout.valid <= tin.valid;
      if (tin.valid) begin
        qvalid <= qvalid_next;
        val    <= val_next;
      end
    end
    if (en) begin
      tout.op        <= tout_next.op;
      tout.char_code <= tout_next.char_code;
      tout.left      <= tout_next.left;
      tout.diag      <= tout_next.diag;
      tout.result    <= tout_next.result;
      tout.placed    <= tout_next.placed;
      if (tin.valid && store) begin
        qchar <= tin.char_code;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/levenshtein_edit_distance.sv =====
// ----------------------------------------------------------------------------
// Levenshtein edit distance
// An op 3 word passes the row of cells and the output register to give
// the result word. Throughput: one word per cycle unless the output stalls;
// the row carries each word one cell per cycle, so depth sets latency, not rate.
// Reset: query empty, truncation flag clear, row entry j holds j.
// ----------------------------------------------------------------------------
`default_nettype none

`include "levenshtein_edit_distance_macros.svh"

module levenshtein_edit_distance (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] char_code
  input  wire logic [1:0]  s_tuser,   // [1:0] op
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [6:0] distance, [7] zero
  output logic [0:0]       m_tuser    // [0] query_truncated
);

  localparam int N = led_pkg::MAX_QUERY_CHARS;

  logic                       en;
  logic [led_pkg::DIST_W-1:0] d0;
  logic                       trunc;
  logic [led_pkg::DIST_W-1:0] score;
  logic                       dist_trunc;
  led_pkg::tok_t              chain [0:N];
  led_pkg::tok_t              last;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign chain[0] = {s_tvalid, s_tuser, s_tdata, led_pkg::sat_inc(d0), d0, d0, 1'b0};

  genvar j;
  generate
    for (j = 1; j <= N; j++) begin : g_cell
      led_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .en     (en),
        .idx    (led_pkg::IDX_W'(j)),
        .tin    (chain[j-1]),
        .tout   (chain[j])
      );
    end
  endgenerate

  assign last = chain[N];

  always_ff @(posedge clk) begin
    if (rst) begin
      d0 <= '0;
    end else if (s_tvalid && en) begin
      if (s_tuser == led_pkg::OP_CHAR) begin
        d0 <= led_pkg::sat_inc(d0);
      end else begin
        d0 <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trunc    <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= last.valid && last.op == led_pkg::OP_END;
      if (last.valid) begin
        case (last.op)
          led_pkg::OP_CLEAR: begin
            trunc <= 1'b0;
          end
          led_pkg::OP_APPEND: begin
            if (!last.placed) begin
              trunc <= 1'b1;
            end
          end
          default: begin
            trunc <= trunc;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && last.valid && last.op == led_pkg::OP_END) begin
      score      <= last.result;
      dist_trunc <= trunc;
    end
  end

  assign m_tdata = {1'b0, score};
  assign m_tuser = dist_trunc;

  `LED_ASSERT_IMP(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready)
  `LED_ASSERT_NXT(a_end_gives_result, en && last.valid && last.op == led_pkg::OP_END, m_tvalid)
  `LED_ASSERT_NXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `LED_ASSERT_NXT(a_drop_flags, en && last.valid && last.op == led_pkg::OP_APPEND && !last.placed, trunc)

endmodule

`default_nettype wire

// ===== dv/levenshtein_edit_distance_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edit distance block test
// Feeds query edits and candidate strings through the stream ports, tracks
// the query and the distance row on the bench side, and compares every
// distance word with the one the bench worked out.
// ----------------------------------------------------------------------------

module levenshtein_edit_distance_test;

  localparam int CYCLE_LIMIT = 500000;
  localparam int WORD_TARGET = 1920;

  typedef struct {
    logic [led_pkg::OP_W-1:0]   op;
    logic [led_pkg::CHAR_W-1:0] code;
    bit                         hold;
  } word_t;

  typedef struct {
    logic [led_pkg::DIST_W-1:0] distance;
    logic                       truncated;
  } score_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [31:0]       s_tdata = '0;    // [31:0] char_code
  logic [1:0]        s_tuser = '0;    // [1:0] op
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [7:0]        m_tdata;         // [6:0] distance, [7] zero
  logic [0:0]        m_tuser;         // [0] query_truncated

  word_t                      words_to_send[$];
  score_t                     awaited_scores[$];
  logic [led_pkg::CHAR_W-1:0] gen_query[$];

  logic [led_pkg::CHAR_W-1:0] query_store[led_pkg::MAX_QUERY_CHARS];
  int                         query_len;
  logic [led_pkg::DIST_W-1:0] dist_row[led_pkg::MAX_QUERY_CHARS+1];
  logic                       trunc_seen;

  int   cycle = 0;
  int   errors = 0;
  int   total_words = 0;
  int   sent_count = 0;
  int   long_runs = 0;
  int   src_gap = 0;
  int   sink_wait = 0;
  bit   src_burst = 0;
  bit   sink_burst = 0;
  logic next_valid;
  word_t  cur;
  score_t got;
  int   scores_seen = 0;
  int   trunc_scores = 0;
  int   sat_scores = 0;
  int   max_score = 0;

  levenshtein_edit_distance u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(input string msg);
    errors++;
    $display("mismatch at cycle %0d: %s", cycle, msg);
  endtask

  function automatic logic [led_pkg::DIST_W-1:0] bump(input logic [led_pkg::DIST_W-1:0] v);
    return (v >= 7'd127) ? 7'd127 : v + 7'd1;
  endfunction

  task automatic reload_dist_row();
    for (int j = 0; j <= led_pkg::MAX_QUERY_CHARS; j++) dist_row[j] = led_pkg::DIST_W'(j);
  endtask

  task automatic init_query_state();
    for (int j = 0; j < led_pkg::MAX_QUERY_CHARS; j++) query_store[j] = '0;
    query_len  = 0;
    trunc_seen = 1'b0;
    reload_dist_row();
  endtask

  // Advance the bench copy of the query and row by one accepted word.
  task automatic apply_word(input logic [led_pkg::OP_W-1:0] op,
                            input logic [led_pkg::CHAR_W-1:0] code);
    logic [led_pkg::DIST_W-1:0] diag;
    logic [led_pkg::DIST_W-1:0] up;
    logic [led_pkg::DIST_W-1:0] m;
    score_t s;
    case (op)
      led_pkg::OP_CLEAR: begin
        query_len  = 0;
        trunc_seen = 1'b0;
        reload_dist_row();
      end
      led_pkg::OP_APPEND: begin
        if (query_len < led_pkg::MAX_QUERY_CHARS) begin
          query_store[query_len] = code;
          query_len++;
        end else begin
          trunc_seen = 1'b1;
        end
        reload_dist_row();
      end
      led_pkg::OP_CHAR: begin
        diag = dist_row[0];
        dist_row[0] = bump(dist_row[0]);
        for (int j = 1; j <= query_len; j++) begin
          up = dist_row[j];
          if (query_store[j-1] == code) begin
            dist_row[j] = diag;
          end else begin
            m = (dist_row[j-1] < up) ? dist_row[j-1] : up;
            if (diag < m) m = diag;
            dist_row[j] = bump(m);
          end
          diag = up;
        end
      end
      default: begin
        s.distance  = dist_row[query_len];
        s.truncated = trunc_seen;
        awaited_scores.insert(awaited_scores.size(), s);
        reload_dist_row();
      end
    endcase
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [led_pkg::CHAR_W-1:0] pick_char();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0061;
      1:       return 32'h0000_0062;
      2:       return 32'h00E4_B8AD;
      3:       return 32'hF09F_9880;
      4:       return 32'h0000_0000;
      5:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [led_pkg::CHAR_W-1:0] pick_cand_char();
    if (gen_query.size() > 0 && $urandom_range(0, 99) < 60)
      return gen_query[$urandom_range(0, gen_query.size() - 1)];
    return pick_char();
  endfunction

  task automatic push_word(input logic [led_pkg::OP_W-1:0] op,
                           input logic [led_pkg::CHAR_W-1:0] code,
                           input bit hold = 0);
    word_t w;
    w.op   = op;
    w.code = code;
    w.hold = hold;
    words_to_send.insert(words_to_send.size(), w);
    total_words++;
    if (op == led_pkg::OP_CLEAR) gen_query.delete();
    if (op == led_pkg::OP_APPEND && gen_query.size() < led_pkg::MAX_QUERY_CHARS)
      gen_query.insert(gen_query.size(), code);
  endtask

  task automatic build_stimulus();
    int r;
    int len;
    // empty query, empty candidate, then one char against an empty query
    push_word(led_pkg::OP_END, 32'hFFFF_FFFF);
    push_word(led_pkg::OP_CHAR, 32'h0000_0000);
    push_word(led_pkg::OP_END, 32'h0000_0000);
    push_word(led_pkg::OP_CLEAR, 32'hFFFF_FFFF);
    push_word(led_pkg::OP_APPEND, 32'h0000_0061);
    push_word(led_pkg::OP_APPEND, 32'hFFFF_FFFF);
    push_word(led_pkg::OP_APPEND, 32'h0000_0000);
    push_word(led_pkg::OP_CHAR, 32'hFFFF_FFFF);
    push_word(led_pkg::OP_CHAR, 32'h0000_0061);
    push_word(led_pkg::OP_CHAR, 32'h0000_0000);
    push_word(led_pkg::OP_END, 32'h1234_5678);
    push_word(led_pkg::OP_END, 32'h0000_0000);
    // query edited while a candidate is open
    push_word(led_pkg::OP_CHAR, 32'h0000_0061);
    push_word(led_pkg::OP_APPEND, 32'h0000_0062);
    push_word(led_pkg::OP_END, 32'h0000_0000);
    push_word(led_pkg::OP_CHAR, 32'h0000_0062);
    push_word(led_pkg::OP_CLEAR, 32'h0000_0000);
    push_word(led_pkg::OP_END, 32'h0000_0000);
    push_word(led_pkg::OP_END, 32'hFFFF_FFFF, 1);

    while (total_words < WORD_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        if ($urandom_range(0, 3) != 0) push_word(led_pkg::OP_CLEAR, $urandom());
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 8);
        repeat (len) push_word(led_pkg::OP_APPEND, pick_char());
      end else if (r < 16) begin
        push_word(led_pkg::OP_W'($urandom_range(0, 3)), $urandom());
      end else begin
        if (long_runs < 3 && $urandom_range(0, 49) == 0) begin
          len = $urandom_range(135, 140);
          long_runs++;
        end else begin
          len = $urandom_range(0, 10);
        end
        repeat (len) push_word(led_pkg::OP_CHAR, pick_cand_char());
        if ($urandom_range(0, 19) == 0) begin
          if ($urandom_range(0, 1) == 0) push_word(led_pkg::OP_APPEND, pick_char());
          else push_word(led_pkg::OP_CLEAR, $urandom());
        end else begin
          push_word(led_pkg::OP_END, $urandom(), $urandom_range(0, 149) == 0);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    cycle++;
    if (cycle > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle);
      $display("levenshtein_edit_distance_test: done, errors");
      $finish;
    end
  end

  // Driver: hold a word until taken, then sometimes wait out a random gap.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      next_valid = s_tvalid;
      if (s_tvalid && s_tready) begin
        apply_word(s_tuser, s_tdata);
        sent_count++;
        next_valid = 1'b0;
        src_gap = (!src_burst && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
      end
      if (!next_valid) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (words_to_send.size() > 0 &&
                     (!words_to_send[0].hold || awaited_scores.size() == 0)) begin
          cur = words_to_send.pop_front();
          s_tdata <= cur.code;
          s_tuser <= cur.op;
          next_valid = 1'b1;
        end
      end
      s_tvalid <= next_valid;
      if ($urandom_range(0, 399) == 0) src_burst = !src_burst;
    end
  end

  // Monitor: check each distance word, stall the output at random.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (awaited_scores.size() == 0) begin
          report($sformatf("unexpected distance word %0d", m_tdata[6:0]));
        end else begin
          got = awaited_scores.pop_front();
          if (m_tdata[6:0] !== got.distance)
            report($sformatf("distance %0d, want %0d", m_tdata[6:0], got.distance));
          if (m_tuser[0] !== got.truncated)
            report($sformatf("truncated %b, want %b", m_tuser[0], got.truncated));
          scores_seen++;
          if (got.truncated) trunc_scores++;
          if (got.distance == 7'd127) sat_scores++;
          if (int'(got.distance) > max_score) max_score = int'(got.distance);
        end
      end
      if (sink_wait > 0) begin
        sink_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!sink_burst && $urandom_range(0, 99) < 20) sink_wait = pick_gap();
      end
      if ($urandom_range(0, 499) == 0) sink_burst = !sink_burst;
    end
  end

  initial begin
    init_query_state();
    build_stimulus();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    while (sent_count < total_words || awaited_scores.size() != 0) @(posedge clk);
    repeat (led_pkg::MAX_QUERY_CHARS + 8) @(posedge clk);
    $display("sent %0d words, checked %0d distances (largest %0d)",
             sent_count, scores_seen, max_score);
    $display("%0d distances carried the truncation flag, %0d hit saturation",
             trunc_scores, sat_scores);
    if (errors == 0) begin
      $display("levenshtein_edit_distance_test: done, clean");
    end else begin
      $display("levenshtein_edit_distance_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== levenshtein_edit_distance.f =====
+incdir+rtl
rtl/led_pkg.sv
rtl/led_cell.sv
rtl/levenshtein_edit_distance.sv
dv/levenshtein_edit_distance_test.sv
